// File: rtl/sfbe_pkg.sv
// Shared types, codes and arithmetic helpers for the spectral fold bandwidth extender.
// No dependencies; used by the core and its checker.
package sfbe_pkg;

	localparam int FRAME_BINS = 1024;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_PROCESS = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	localparam logic [1:0] EXT_OFF  = 2'd0;
	localparam logic [1:0] EXT_AUTO = 2'd2;

	localparam logic [2:0] REG_EXT_MODE = 3'd0;
	localparam logic [2:0] REG_BITRATE  = 3'd1;
	localparam logic [2:0] REG_SRATE    = 3'd2;
	localparam logic [2:0] REG_ROLLOFF  = 3'd3;
	localparam logic [2:0] REG_HOLE     = 3'd4;

	localparam logic [19:0] AUTO_MAX_BITRATE = 20'd48000;
	localparam logic [17:0] AUTO_MIN_SRATE   = 18'd32000;

	localparam logic [14:0] GAIN_MAX_Q14  = 15'd19661;
	localparam logic [14:0] GAIN_MIN_Q14  = 15'd4915;
	localparam logic [15:0] FADE_STEP_Q14 = 16'd963;
	localparam logic [30:0] RATIO_CAP     = 31'h4000_0000;
	localparam logic [30:0] RATIO_UNITY   = 31'd16384;

	localparam int FACT_W = 16;

	typedef enum logic [2:0] {
		OP_ACC_UP,
		OP_ACC_PA,
		OP_COPY,
		OP_FADE
	} op_kind_t;

	function automatic logic [31:0] magnitude(input logic [31:0] w);
		return w[31] ? (~w + 32'd1) : w;
	endfunction

	// Round half away from zero, keep sign, saturate to 32-bit signed.
	function automatic logic [31:0] scale_q14(input logic [31:0] w, input logic [FACT_W-1:0] f);
		logic [47:0] p;
		logic [33:0] r;
		p = 48'(magnitude(w)) * 48'(f) + 48'd8192;
		r = p[47:14];
		if (w[31]) begin
			if (r > 34'h0_8000_0000)
				r = 34'h0_8000_0000;
			return 32'd0 - r[31:0];
		end
		if (r > 34'h0_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return r[31:0];
	endfunction

endpackage

// File: rtl/spectral_fold_bandwidth_extender_core.sv
// Spectral fold bandwidth extender core: frame store, gain divider and patch copy engine.
// Depends on sfbe_pkg.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | mode bin_index coefficient core_count long_window
//  out     | output    | out_valid / out_ready | read_value applied extension_bins patch_start
//          |           |                       | gain_used
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// Write and read words go through the frame memory; a read word passes through the memory
// read register and then the output register. A process word runs through the sum, divide,
// gain, copy and fade states, paced by the single memory read port and the one-bit-per-cycle
// divider; no new word is taken until it finishes.
// Reset sets registers to defaults; the frame memory holds no defined value until written.
// The output register lets input continue while a result waits; a stalled output
// holds further read and process words.
module spectral_fold_bandwidth_extender_core #(
	parameter int ENERGY_SPAN = 64,
	parameter int FADE_SPAN   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [9:0]  bin_index,
	input  logic signed [31:0] coefficient,
	input  logic [10:0] core_count,
	input  logic        long_window,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] read_value,
	output logic        applied,
	output logic [9:0]  extension_bins,
	output logic [9:0]  patch_start,
	output logic [14:0] gain_used,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FRAME_BINS = sfbe_pkg::FRAME_BINS;
	localparam int AW  = $clog2(FRAME_BINS);
	localparam int CW  = $clog2(FRAME_BINS + 1);
	localparam int SW  = 32 + $clog2(ENERGY_SPAN + 1);
	localparam int NW  = SW + 14;
	localparam int DCW = $clog2(NW + 1);
	localparam int FW  = sfbe_pkg::FACT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_SUM, ST_SUM_WAIT, ST_DIV_INIT, ST_DIV,
		ST_GAIN, ST_COPY, ST_COPY_WAIT, ST_FADE, ST_FADE_WAIT, ST_FIN
	} state_t;

	state_t state_q;

	logic [1:0]  ext_mode_q;
	logic [19:0] bitrate_q;
	logic [17:0] srate_q;
	logic [14:0] rolloff_q;
	logic [30:0] hole_q;

	logic [31:0] mem [FRAME_BINS];
	logic [31:0] mem_rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd;

	logic [AW-1:0] core_q, ext_q, patch_q, alen_q;
	logic [CW-1:0] fade_n_q, cnt_q;
	logic          skip_q, phase_q;
	logic [SW-1:0] up_q, pa_q;
	logic [NW-1:0] num_q, quo_q;
	logic [SW:0]   rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [14:0]   gain_q;

	logic            op_v_s1, op_par_s1;
	sfbe_pkg::op_kind_t op_kind_s1;
	logic [AW-1:0]   op_addr_s1;
	logic [FW-1:0]   op_fac_s1;
	logic            rd_v_s1, rd_ok_s1;

	logic        out_valid_q, applied_q;
	logic [31:0] read_value_q;
	logic [9:0]  ext_out_q, patch_out_q;
	logic [14:0] gain_out_q;

	logic in_fire, out_free, in_range, skip_now;
	logic [31:0] core32, half32, ext32, alen32, room32, fade32;
	logic [31:0] scaled, wd_s1, hole32;
	logic [SW:0] rem_sh;
	logic        rem_ge;
	logic [30:0] ratio;
	logic [45:0] prod;
	logic [31:0] gain_raw;
	logic [FW-1:0] fade_fac;
	logic        mode_on;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && (!rd_v_s1 || out_free);
	assign in_fire   = in_valid && in_ready;

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign applied        = applied_q;
	assign extension_bins = ext_out_q;
	assign patch_start    = patch_out_q;
	assign gain_used      = gain_out_q;

	always_comb begin
		in_range = 32'(bin_index) < 32'(FRAME_BINS);
		core32   = 32'(core_count);
		half32   = core32 >> 1;
		ext32    = (core32 + half32 > 32'(FRAME_BINS)) ? 32'(FRAME_BINS) - core32 : half32;
		alen32   = (ext32 < 32'(ENERGY_SPAN)) ? ext32 : 32'(ENERGY_SPAN);
		room32   = 32'(FRAME_BINS) - core32;
		fade32   = (room32 < 32'(FADE_SPAN)) ? room32 : 32'(FADE_SPAN);
		if (ext_mode_q == sfbe_pkg::EXT_OFF)
			mode_on = 1'b0;
		else if (ext_mode_q == sfbe_pkg::EXT_AUTO)
			mode_on = !(bitrate_q > sfbe_pkg::AUTO_MAX_BITRATE ||
				srate_q < sfbe_pkg::AUTO_MIN_SRATE);
		else
			mode_on = 1'b1;
		skip_now = !long_window || !mode_on || core32 >= 32'(FRAME_BINS) || ext32 == 32'd0;
	end

	always_comb begin
		hole32 = {1'b0, hole_q};
		scaled = sfbe_pkg::scale_q14(mem_rd_q, op_fac_s1);
		if (op_kind_s1 == sfbe_pkg::OP_COPY && scaled == 32'd0)
			wd_s1 = op_par_s1 ? hole32 : 32'd0 - hole32;
		else
			wd_s1 = scaled;
		fade_fac = FW'((32'(cnt_q) + 32'd1) * 32'(sfbe_pkg::FADE_STEP_Q14));
		rem_sh   = {rem_q[SW-1:0], num_q[NW-1]};
		rem_ge   = rem_sh >= {1'b0, pa_q};
		ratio    = (quo_q > NW'(sfbe_pkg::RATIO_CAP)) ? sfbe_pkg::RATIO_CAP : quo_q[30:0];
		prod     = 46'(rolloff_q) * 46'(ratio);
		gain_raw = prod[45:14];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(bin_index);
		mem_wd = coefficient;
		if (in_fire && mode == sfbe_pkg::MODE_WRITE && in_range)
			mem_we = 1'b1;
		else if (op_v_s1 && (op_kind_s1 == sfbe_pkg::OP_COPY ||
				op_kind_s1 == sfbe_pkg::OP_FADE)) begin
			mem_we = 1'b1;
			mem_wa = op_addr_s1;
			mem_wd = wd_s1;
		end
		mem_re = 1'b0;
		mem_ra = AW'(bin_index);
		case (state_q)
			ST_IDLE: begin
				mem_re = in_fire && mode == sfbe_pkg::MODE_READ && in_range;
			end
			ST_SUM: begin
				mem_re = 1'b1;
				mem_ra = phase_q ? patch_q + AW'(cnt_q) : core_q - AW'(1) - AW'(cnt_q);
			end
			ST_COPY: begin
				mem_re = 1'b1;
				mem_ra = patch_q + AW'(cnt_q);
			end
			ST_FADE: begin
				mem_re = 1'b1;
				mem_ra = core_q + AW'(cnt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ext_mode_q   <= 2'd2;
			bitrate_q    <= '0;
			srate_q      <= 18'd48000;
			rolloff_q    <= 15'd16384;
			hole_q       <= 31'd1;
			core_q       <= '0;
			ext_q        <= '0;
			patch_q      <= '0;
			alen_q       <= '0;
			fade_n_q     <= '0;
			cnt_q        <= '0;
			skip_q       <= 1'b0;
			phase_q      <= 1'b0;
			up_q         <= '0;
			pa_q         <= '0;
			num_q        <= '0;
			quo_q        <= '0;
			rem_q        <= '0;
			dcnt_q       <= '0;
			gain_q       <= '0;
			op_v_s1      <= 1'b0;
			op_par_s1    <= 1'b0;
			op_kind_s1   <= sfbe_pkg::OP_ACC_UP;
			op_addr_s1   <= '0;
			op_fac_s1    <= '0;
			rd_v_s1      <= 1'b0;
			rd_ok_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			applied_q    <= 1'b0;
			read_value_q <= '0;
			ext_out_q    <= '0;
			patch_out_q  <= '0;
			gain_out_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sfbe_pkg::REG_EXT_MODE: ext_mode_q <= cfg_data[1:0];
					sfbe_pkg::REG_BITRATE:  bitrate_q  <= cfg_data[19:0];
					sfbe_pkg::REG_SRATE:    srate_q    <= cfg_data[17:0];
					sfbe_pkg::REG_ROLLOFF:  rolloff_q  <= cfg_data[14:0];
					sfbe_pkg::REG_HOLE:     hole_q     <= cfg_data[30:0];
					default: ;
				endcase
			end

			if (op_v_s1 && op_kind_s1 == sfbe_pkg::OP_ACC_UP)
				up_q <= up_q + SW'(sfbe_pkg::magnitude(mem_rd_q));
			if (op_v_s1 && op_kind_s1 == sfbe_pkg::OP_ACC_PA)
				pa_q <= pa_q + SW'(sfbe_pkg::magnitude(mem_rd_q));
			op_v_s1 <= 1'b0;

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (rd_v_s1 && out_free) begin
				out_valid_q  <= 1'b1;
				read_value_q <= rd_ok_s1 ? mem_rd_q : 32'd0;
				applied_q    <= 1'b0;
				ext_out_q    <= '0;
				patch_out_q  <= '0;
				gain_out_q   <= '0;
				rd_v_s1      <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && mode == sfbe_pkg::MODE_READ) begin
						rd_v_s1  <= 1'b1;
						rd_ok_s1 <= in_range;
					end
					if (in_fire && mode == sfbe_pkg::MODE_PROCESS) begin
						core_q   <= AW'(core32);
						ext_q    <= AW'(ext32);
						patch_q  <= AW'(half32);
						alen_q   <= AW'(alen32);
						fade_n_q <= CW'(fade32);
						skip_q   <= skip_now;
						state_q  <= ST_START;
					end
				end
				ST_START: begin
					if (!rd_v_s1) begin
						up_q    <= '0;
						pa_q    <= '0;
						cnt_q   <= '0;
						phase_q <= 1'b0;
						state_q <= skip_q ? ST_FIN : ST_SUM;
					end
				end
				ST_SUM: begin
					op_v_s1    <= 1'b1;
					op_kind_s1 <= phase_q ? sfbe_pkg::OP_ACC_PA : sfbe_pkg::OP_ACC_UP;
					phase_q    <= !phase_q;
					if (phase_q) begin
						if (cnt_q == CW'(alen_q) - CW'(1))
							state_q <= ST_SUM_WAIT;
						else
							cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SUM_WAIT: state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					if (pa_q == '0) begin
						quo_q   <= (up_q == '0) ? NW'(sfbe_pkg::RATIO_UNITY)
							: NW'(sfbe_pkg::RATIO_CAP);
						state_q <= ST_GAIN;
					end else begin
						num_q   <= {up_q, 14'd0};
						rem_q   <= '0;
						quo_q   <= '0;
						dcnt_q  <= DCW'(NW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_ge ? rem_sh - {1'b0, pa_q} : rem_sh;
					quo_q  <= {quo_q[NW-2:0], rem_ge};
					num_q  <= num_q << 1;
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == '0)
						state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (gain_raw > 32'(sfbe_pkg::GAIN_MAX_Q14))
						gain_q <= sfbe_pkg::GAIN_MAX_Q14;
					else if (gain_raw < 32'(sfbe_pkg::GAIN_MIN_Q14))
						gain_q <= sfbe_pkg::GAIN_MIN_Q14;
					else
						gain_q <= gain_raw[14:0];
					cnt_q   <= '0;
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					op_v_s1    <= 1'b1;
					op_kind_s1 <= sfbe_pkg::OP_COPY;
					op_addr_s1 <= core_q + AW'(cnt_q);
					op_fac_s1  <= FW'(gain_q);
					op_par_s1  <= cnt_q[0];
					if (cnt_q == CW'(ext_q) - CW'(1)) begin
						cnt_q   <= '0;
						state_q <= ST_COPY_WAIT;
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				ST_COPY_WAIT: state_q <= ST_FADE;
				ST_FADE: begin
					op_v_s1    <= 1'b1;
					op_kind_s1 <= sfbe_pkg::OP_FADE;
					op_addr_s1 <= core_q + AW'(cnt_q);
					op_fac_s1  <= fade_fac;
					op_par_s1  <= 1'b0;
					if (cnt_q == fade_n_q - CW'(1))
						state_q <= ST_FADE_WAIT;
					else
						cnt_q <= cnt_q + CW'(1);
				end
				ST_FADE_WAIT: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free && !rd_v_s1) begin
						out_valid_q  <= 1'b1;
						read_value_q <= '0;
						applied_q    <= !skip_q;
						ext_out_q    <= skip_q ? 10'd0 : 10'(ext_q);
						patch_out_q  <= skip_q ? 10'd0 : 10'(patch_q);
						gain_out_q   <= skip_q ? 15'd0 : gain_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/sfbe_checker.sv
// Port-level checker for the bandwidth extender core, bound to the core module.
// Depends on sfbe_pkg and spectral_fold_bandwidth_extender_core.
module sfbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_value,
	input logic        applied,
	input logic [9:0]  extension_bins,
	input logic [9:0]  patch_start,
	input logic [14:0] gain_used
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(gain_used))
		else $error("result word changed while stalled");

	a_applied_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && applied |-> read_value == 32'd0 && extension_bins != 10'd0)
		else $error("extended result carries read value or empty extension");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && applied |-> gain_used >= sfbe_pkg::GAIN_MIN_Q14 &&
			gain_used <= sfbe_pkg::GAIN_MAX_Q14)
		else $error("gain out of clamp range");

	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !applied |-> extension_bins == 10'd0 && patch_start == 10'd0 &&
			gain_used == 15'd0)
		else $error("unextended result carries extension fields");

endmodule

bind spectral_fold_bandwidth_extender_core sfbe_checker u_sfbe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_value(read_value),
	.applied(applied),
	.extension_bins(extension_bins),
	.patch_start(patch_start),
	.gain_used(gain_used)
);
